// ===== rtl/core/owbm_pkg.sv =====
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared types, codes and register defaults of the 1-Wire bus master core.
// ----------------------------------------------------------------------------
package owbm_pkg;

    // operation codes on the input tuser field
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_RESET = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // timing register indexes
    localparam int NUM_CFG   = 8;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_TAIL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LOW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_SLOT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_TAIL     = 3'd7;

    // register reset values, index 0 in the lowest slot
    localparam logic [NUM_CFG-1:0][CFG_W-1:0] CFG_DEFAULTS = {
        16'd45, 16'd15, 16'd5, 16'd60, 16'd2, 16'd500, 16'd70, 16'd500
    };

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // stream payload widths
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;

    // item classes produced by the front
    typedef enum logic [1:0] {
        KIND_TICK,
        KIND_RESET,
        KIND_WRITE,
        KIND_READ
    } kind_t;

    // classified item carried through the queue
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
        logic       bus_level;
    } item_t;

    // one result item
    typedef struct packed {
        logic       rejected;
        logic [7:0] result_data;
        logic       done_res;
        logic       busy_res;
        logic       bus_drive_low;
    } result_t;

    // sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_WAIT,
        PH_RST_TAIL,
        PH_W_LOW,
        PH_W_HIGH,
        PH_R_LOW,
        PH_R_WAIT,
        PH_R_TAIL
    } phase_t;

endpackage

// ===== rtl/core/owbm_front.sv =====
// ----------------------------------------------------------------------------
// owbm_front
// Input register stage: accepts stream transfers and classifies each item.
// ----------------------------------------------------------------------------
module owbm_front
    import owbm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 item_valid,
    input  logic                 item_ready,
    output item_t                item
);

    logic  valid_reg;
    item_t item_reg;
    kind_t kind_dec;

    // decode the operation code
    always_comb begin
        case (s_tuser)
            OP_TICK:  kind_dec = KIND_TICK;
            OP_RESET: kind_dec = KIND_RESET;
            OP_WRITE: kind_dec = KIND_WRITE;
            OP_READ:  kind_dec = KIND_READ;
            default:  kind_dec = KIND_TICK;
        endcase
    end

    // no transfer is taken while reset is held
    assign s_tready = aresetn && (!valid_reg || item_ready);

    // stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.kind      <= kind_dec;
            item_reg.data_byte <= s_tdata[7:0];
            item_reg.bus_level <= s_tdata[8];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/core/owbm_queue.sv =====
// ----------------------------------------------------------------------------
// owbm_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module owbm_queue
    import owbm_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    item_t            mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_item   = mem[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/core/owbm_back.sv =====
// ----------------------------------------------------------------------------
// owbm_back
// Slot sequencer: timing registers, bus phases and the registered result.
// ----------------------------------------------------------------------------
module owbm_back
    import owbm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  item_t                item,
    output logic                 res_valid,
    input  logic                 res_ready,
    output result_t              res
);

    logic [NUM_CFG-1:0][CFG_W-1:0] cfg_reg;

    phase_t      phase_reg, phase_next;
    logic [15:0] tick_count_reg, tick_count_next;
    logic [2:0]  bit_index_reg, bit_index_next;
    logic [7:0]  shift_byte_reg, shift_byte_next;
    logic        out_valid_reg;
    result_t     out_reg, out_next;

    logic [15:0] len_raw, len, cnt_inc;
    logic        take, done, rejected;
    logic [7:0]  result;

    // timing registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_DEFAULTS;
        end else if (cfg_wr_en) begin
            cfg_reg[cfg_index] <= cfg_wdata;
        end
    end

    // an item is processed when the output register can take its result
    assign item_ready = !out_valid_reg || res_ready;
    assign take       = item_valid && item_ready;

    // length of the current phase
    always_comb begin
        case (phase_reg)
            PH_RST_LOW:  len_raw = cfg_reg[CFG_RESET_LOW];
            PH_RST_WAIT: len_raw = cfg_reg[CFG_PRESENCE_WAIT];
            PH_RST_TAIL: len_raw = cfg_reg[CFG_RESET_TAIL];
            PH_W_LOW:    len_raw = shift_byte_reg[0] ? cfg_reg[CFG_SHORT_LOW]
                                                     : cfg_reg[CFG_LONG_SLOT];
            PH_W_HIGH:   len_raw = shift_byte_reg[0] ? cfg_reg[CFG_LONG_SLOT]
                                                     : cfg_reg[CFG_RECOVERY];
            PH_R_LOW:    len_raw = cfg_reg[CFG_SHORT_LOW];
            PH_R_WAIT:   len_raw = cfg_reg[CFG_READ_SAMPLE];
            PH_R_TAIL:   len_raw = cfg_reg[CFG_READ_TAIL];
            default:     len_raw = 16'd1;
        endcase
        len     = (len_raw == 16'd0) ? 16'd1 : len_raw;
        cnt_inc = (tick_count_reg != 16'hFFFF) ? tick_count_reg + 16'd1 : tick_count_reg;
    end

    // next state and result of one item
    always_comb begin
        phase_next      = phase_reg;
        tick_count_next = tick_count_reg;
        bit_index_next  = bit_index_reg;
        shift_byte_next = shift_byte_reg;
        done            = 1'b0;
        rejected        = 1'b0;
        result          = 8'd0;

        if (item.kind != KIND_TICK) begin
            if (phase_reg != PH_IDLE) begin
                rejected = 1'b1;
            end else begin
                tick_count_next = 16'd0;
                bit_index_next  = 3'd0;
                case (item.kind)
                    KIND_RESET: begin
                        shift_byte_next = 8'd0;
                        phase_next      = PH_RST_LOW;
                    end
                    KIND_WRITE: begin
                        shift_byte_next = item.data_byte;
                        phase_next      = PH_W_LOW;
                    end
                    default: begin
                        shift_byte_next = 8'd0;
                        phase_next      = PH_R_LOW;
                    end
                endcase
            end
        end else if (phase_reg != PH_IDLE) begin
            tick_count_next = cnt_inc;
            if (cnt_inc >= len) begin
                tick_count_next = 16'd0;
                case (phase_reg)
                    PH_RST_LOW:  phase_next = PH_RST_WAIT;
                    PH_RST_WAIT: begin
                        shift_byte_next = {7'd0, item.bus_level};
                        phase_next      = PH_RST_TAIL;
                    end
                    PH_RST_TAIL: begin
                        done   = 1'b1;
                        result = {7'd0, shift_byte_reg[0]};
                    end
                    PH_W_LOW:    phase_next = PH_W_HIGH;
                    PH_W_HIGH: begin
                        if (bit_index_reg == 3'd7) begin
                            done = 1'b1;
                        end else begin
                            bit_index_next  = bit_index_reg + 3'd1;
                            shift_byte_next = {1'b0, shift_byte_reg[7:1]};
                            phase_next      = PH_W_LOW;
                        end
                    end
                    PH_R_LOW:    phase_next = PH_R_WAIT;
                    PH_R_WAIT: begin
                        shift_byte_next = {item.bus_level, shift_byte_reg[7:1]};
                        phase_next      = PH_R_TAIL;
                    end
                    PH_R_TAIL: begin
                        if (bit_index_reg == 3'd7) begin
                            done   = 1'b1;
                            result = shift_byte_reg;
                        end else begin
                            bit_index_next = bit_index_reg + 3'd1;
                            phase_next     = PH_R_LOW;
                        end
                    end
                    default:     phase_next = PH_IDLE;
                endcase
                if (done) begin
                    phase_next     = PH_IDLE;
                    bit_index_next = 3'd0;
                end
            end
        end

        out_next.bus_drive_low = (phase_next == PH_RST_LOW) || (phase_next == PH_W_LOW)
                                 || (phase_next == PH_R_LOW);
        out_next.busy_res      = (phase_next != PH_IDLE);
        out_next.done_res      = done;
        out_next.result_data   = result;
        out_next.rejected      = rejected;
    end

    // sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            tick_count_reg <= 16'd0;
            bit_index_reg  <= 3'd0;
            shift_byte_reg <= 8'd0;
        end else if (take) begin
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
            bit_index_reg  <= bit_index_next;
            shift_byte_reg <= shift_byte_next;
        end
    end

    // output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (item_ready) begin
            out_valid_reg <= item_valid;
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (take) begin
            out_reg <= out_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

// ===== rtl/core/one_wire_bus_master_core.sv =====
// ----------------------------------------------------------------------------
// one_wire_bus_master_core
// 1-Wire bus master with reset/presence, write byte and read byte sequences.
// ----------------------------------------------------------------------------
// Usage:
// - slave stream s_*: one transfer per item; s_tuser holds the operation
//   (tick, reset, write byte, read byte), s_tdata the data byte and the
//   sampled bus level. Ticks pace the slot timer, one per microsecond.
// - master stream m_*: exactly one result transfer per input item, in order,
//   with line drive, busy, done, result byte and rejected flag.
// - cfg_*: plain write port for the eight slot timing registers; write only
//   while the core is idle.
// Throughput is one item per cycle while m_tready is high. From input transfer
// to result an item passes the front register, a queue entry and the output
// register of the sequencer. The sequencer handles any item with a 16-bit compare.
// Reset (aresetn low, synchronous) empties front, queue and output stages,
// returns the sequencer to idle and the timing registers to their defaults.
// When m_tready is low the output register holds its transfer, the queue
// fills, and s_tready drops once front and queue are full.
// ----------------------------------------------------------------------------
module one_wire_bus_master_core
    import owbm_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    // input items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // [7:0] data_byte, [8] bus_level, [15:9] zero
    input  logic [S_TUSER_W-1:0] s_tuser,  // [1:0] operation
    // result items
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // [0] bus_drive_low, [1] busy_res,
                                           // [2] done_res, [10:3] result_data,
                                           // [11] rejected, [15:12] zero
);

    logic    fr_valid, fr_ready;
    item_t   fr_item;
    logic    q_valid, q_ready;
    item_t   q_item;
    result_t res;

    // front: accept and classify
    owbm_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (fr_valid),
        .item_ready (fr_ready),
        .item       (fr_item)
    );

    // queue between front and back
    owbm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fr_valid),
        .push_ready (fr_ready),
        .push_item  (fr_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_item   (q_item)
    );

    // back: slot sequencer
    owbm_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res        (res)
    );

    // pack the result transfer
    assign m_tdata = {4'd0, res.rejected, res.result_data, res.done_res,
                      res.busy_res, res.bus_drive_low};

endmodule

// ===== rtl/core/owbm_checker.sv =====
// ----------------------------------------------------------------------------
// owbm_checker
// Port-level checks of the 1-Wire bus master core, bound to the top level.
// ----------------------------------------------------------------------------
module owbm_checker
    import owbm_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // no result transfer is offered right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result offered after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // a completing item leaves the master idle and released
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2] |-> !m_tdata[1] && !m_tdata[0])
        else $error("done while busy or driving");

    // a rejected command only happens during a running sequence
    a_reject_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[11] |-> m_tdata[1] && !m_tdata[2])
        else $error("rejection while idle");

    // result byte is zero except on done
    a_result_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[2] |-> m_tdata[10:3] == 8'd0)
        else $error("result byte without done");

endmodule

bind one_wire_bus_master_core owbm_checker u_owbm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== test/one_wire_bus_master_core_test.sv =====
// ----------------------------------------------------------------------------
// one_wire_bus_master_core_test
// Self-checking bench for the 1-Wire bus master core. A transfer-level predictor
// follows every accepted input transfer and queues the result it expects;
// each result transfer is compared field by field with the oldest entry.
// Directed tests cover default timing, short slots, zero-length slots
// and a long reset pulse; random tests run command sequences with
// random timing, bus levels, rejected commands and gaps on both streams.
// ----------------------------------------------------------------------------
module one_wire_bus_master_core_test;
    import owbm_pkg::*;

    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int QUIET_CYCLES  = 10;
    localparam int RANDOM_ITEMS  = 100;
    localparam int REPORT_MAX    = 10;

    typedef logic [CFG_W-1:0] timing_set_t [NUM_CFG];
    typedef enum {LVL_RANDOM, LVL_LOW, LVL_HIGH} level_mode_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;  // [7:0] data_byte, [8] bus_level
    logic [S_TUSER_W-1:0] s_tuser   = OP_TICK;  // [1:0] operation
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;  // [0] drive low, [1] busy, [2] done,
                                    // [10:3] result byte, [11] rejected

    // predictor state and timing registers
    phase_t      cur_phase = PH_IDLE;
    logic [15:0] tick_cnt  = '0;
    logic [2:0]  bit_idx   = '0;
    logic [7:0]  shift_reg = '0;
    logic [15:0] timing [NUM_CFG];

    result_t line_results_q [$];
    int      mismatch_count = 0;
    int      work_items     = 0;
    int      cycle_count    = 0;
    int      stall_left     = 0;
    bit      gaps_on        = 1'b1;

    one_wire_bus_master_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side stalls in random bursts
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 9);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[11:0]);
            if (line_results_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected result transfer: %h", m_tdata);
            end else begin
                want = line_results_q.pop_front();
                if (got.bus_drive_low !== want.bus_drive_low ||
                    got.busy_res !== want.busy_res ||
                    got.done_res !== want.done_res ||
                    got.result_data !== want.result_data ||
                    got.rejected !== want.rejected) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display({"mismatch: expected drv=%b busy=%b done=%b data=%h rej=%b,",
                                  " got drv=%b busy=%b done=%b data=%h rej=%b"},
                                 want.bus_drive_low, want.busy_res, want.done_res,
                                 want.result_data, want.rejected,
                                 got.bus_drive_low, got.busy_res, got.done_res,
                                 got.result_data, got.rejected);
                end
            end
        end
    end

    // length of the running phase in ticks
    function automatic logic [15:0] slot_length();
        case (cur_phase)
            PH_RST_LOW:  return timing[CFG_RESET_LOW];
            PH_RST_WAIT: return timing[CFG_PRESENCE_WAIT];
            PH_RST_TAIL: return timing[CFG_RESET_TAIL];
            PH_W_LOW:    return shift_reg[0] ? timing[CFG_SHORT_LOW] : timing[CFG_LONG_SLOT];
            PH_W_HIGH:   return shift_reg[0] ? timing[CFG_LONG_SLOT] : timing[CFG_RECOVERY];
            PH_R_LOW:    return timing[CFG_SHORT_LOW];
            PH_R_WAIT:   return timing[CFG_READ_SAMPLE];
            PH_R_TAIL:   return timing[CFG_READ_TAIL];
            default:     return 16'd1;
        endcase
    endfunction

    // advance the sequencer by one item and queue the line result
    task automatic advance_sequencer(input logic [1:0] op, input logic [7:0] data,
                                     input logic level);
        result_t     r;
        logic [15:0] len;
        r = '0;
        if (op != OP_TICK) begin
            if (cur_phase != PH_IDLE) begin
                r.rejected = 1'b1;
            end else begin
                tick_cnt = '0;
                bit_idx  = '0;
                case (op)
                    OP_RESET: begin
                        shift_reg = '0;
                        cur_phase = PH_RST_LOW;
                    end
                    OP_WRITE: begin
                        shift_reg = data;
                        cur_phase = PH_W_LOW;
                    end
                    default: begin
                        shift_reg = '0;
                        cur_phase = PH_R_LOW;
                    end
                endcase
            end
        end else if (cur_phase != PH_IDLE) begin
            len = slot_length();
            if (len == 16'd0)
                len = 16'd1;
            if (tick_cnt != 16'hFFFF)
                tick_cnt++;
            if (tick_cnt >= len) begin
                tick_cnt = '0;
                case (cur_phase)
                    PH_RST_LOW: cur_phase = PH_RST_WAIT;
                    PH_RST_WAIT: begin
                        shift_reg = {7'd0, level};
                        cur_phase = PH_RST_TAIL;
                    end
                    PH_RST_TAIL: begin
                        r.done_res    = 1'b1;
                        r.result_data = {7'd0, shift_reg[0]};
                    end
                    PH_W_LOW: cur_phase = PH_W_HIGH;
                    PH_W_HIGH: begin
                        if (bit_idx == 3'd7) begin
                            r.done_res = 1'b1;
                        end else begin
                            bit_idx++;
                            shift_reg = shift_reg >> 1;
                            cur_phase = PH_W_LOW;
                        end
                    end
                    PH_R_LOW: cur_phase = PH_R_WAIT;
                    PH_R_WAIT: begin
                        shift_reg = {level, shift_reg[7:1]};
                        cur_phase = PH_R_TAIL;
                    end
                    PH_R_TAIL: begin
                        if (bit_idx == 3'd7) begin
                            r.done_res    = 1'b1;
                            r.result_data = shift_reg;
                        end else begin
                            bit_idx++;
                            cur_phase = PH_R_LOW;
                        end
                    end
                    default: cur_phase = PH_IDLE;
                endcase
                if (r.done_res) begin
                    cur_phase = PH_IDLE;
                    bit_idx   = '0;
                end
            end
        end
        r.bus_drive_low = (cur_phase == PH_RST_LOW) || (cur_phase == PH_W_LOW) ||
                          (cur_phase == PH_R_LOW);
        r.busy_res = (cur_phase != PH_IDLE);
        line_results_q.push_back(r);
    endtask

    // one input transfer, with an optional gap in front
    task automatic send_item(input logic [1:0] op, input logic [7:0] data, input logic level);
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, level, data};
        do @(posedge aclk); while (!s_tready);
        if (op != OP_TICK || cur_phase != PH_IDLE)
            work_items++;
        advance_sequencer(op, data, level);
    endtask

    // hold input until every expected result is back, then let the core rest
    task automatic settle();
        s_tvalid <= 1'b0;
        while (line_results_q.size() != 0) @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    // write all timing registers, core must be idle
    task automatic program_timing(input timing_set_t vals);
        for (int i = 0; i < NUM_CFG; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_wdata <= vals[i];
            @(posedge aclk);
            timing[i] = vals[i];
        end
        cfg_wr_en <= 1'b0;
    endtask

    // start a command and tick it to completion
    task automatic run_command(input logic [1:0] op, input logic [7:0] data,
                               input level_mode_t mode, input bit noisy);
        logic lvl;
        send_item(op, data, 1'($urandom_range(0, 1)));
        while (cur_phase != PH_IDLE) begin
            case (mode)
                LVL_LOW:  lvl = 1'b0;
                LVL_HIGH: lvl = 1'b1;
                default:  lvl = 1'($urandom_range(0, 1));
            endcase
            // a command while busy must be turned away
            if (noisy && $urandom_range(0, 15) == 0)
                send_item(2'($urandom_range(1, 3)), 8'($urandom), lvl);
            else
                send_item(OP_TICK, 8'($urandom), lvl);
        end
    endtask

    // mostly short slots, sometimes zero or longer ones
    function automatic timing_set_t random_timing();
        timing_set_t t;
        int          r;
        for (int i = 0; i < NUM_CFG; i++) begin
            r = $urandom_range(0, 9);
            if (r == 0)
                t[i] = 16'd0;
            else if (r == 1)
                t[i] = 16'($urandom_range(3, 8));
            else
                t[i] = 16'($urandom_range(1, 2));
        end
        return t;
    endfunction

    // reset values after reset: one byte out with the default slots
    task automatic test_default_timing();
        send_item(OP_TICK, 8'hFF, 1'b1);
        run_command(OP_WRITE, 8'hA5, LVL_RANDOM, 1'b1);
        settle();
    endtask

    // short slots: byte extremes, fixed read levels, no presence
    task automatic test_short_slots();
        program_timing('{16'd2, 16'd1, 16'd2, 16'd1, 16'd2, 16'd1, 16'd1, 16'd1});
        run_command(OP_WRITE, 8'h00, LVL_RANDOM, 1'b0);
        run_command(OP_WRITE, 8'hFF, LVL_RANDOM, 1'b1);
        run_command(OP_WRITE, 8'h5A, LVL_RANDOM, 1'b0);
        run_command(OP_READ, 8'h00, LVL_HIGH, 1'b0);
        run_command(OP_READ, 8'hFF, LVL_LOW, 1'b1);
        run_command(OP_READ, 8'h3C, LVL_RANDOM, 1'b0);
        run_command(OP_RESET, 8'h00, LVL_HIGH, 1'b1);
        send_item(OP_TICK, 8'h00, 1'b0);
        // the first command starts a reset; each command sent while it runs is rejected
        send_item(OP_RESET, 8'h00, 1'b0);
        send_item(OP_WRITE, 8'hFF, 1'b1);
        send_item(OP_READ, 8'h00, 1'b0);
        send_item(OP_RESET, 8'h00, 1'b1);
        while (cur_phase != PH_IDLE) send_item(OP_TICK, 8'($urandom), 1'b0);
        settle();
    endtask

    // zero slot lengths act as a single tick
    task automatic test_zero_slots();
        program_timing('{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0});
        run_command(OP_RESET, 8'h00, LVL_LOW, 1'b0);
        run_command(OP_WRITE, 8'hC3, LVL_RANDOM, 1'b0);
        run_command(OP_READ, 8'h00, LVL_RANDOM, 1'b0);
        settle();
    endtask

    // long reset pulse with single-tick wait and tail
    task automatic test_long_reset();
        gaps_on = 1'b0;
        program_timing('{16'd60, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1});
        run_command(OP_RESET, 8'h00, LVL_RANDOM, 1'b0);
        settle();
        gaps_on = 1'b1;
    endtask

    // random timing, random commands and noise, one pause mid stream
    task automatic test_random_traffic();
        int start;
        int chunk;
        start = work_items;
        chunk = 0;
        while (work_items - start < RANDOM_ITEMS) begin
            settle();
            program_timing(random_timing());
            gaps_on = ($urandom_range(0, 3) != 0);
            for (int k = 0; k < 6; k++) begin
                if (chunk == 0 && k == 3)
                    settle();
                if ($urandom_range(0, 9) == 0)
                    send_item(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom_range(0, 1)));
                else
                    run_command(2'($urandom_range(1, 3)), 8'($urandom), LVL_RANDOM, 1'b1);
            end
            chunk++;
        end
        settle();
    endtask

    // last stretch with both sides always ready
    task automatic test_no_gaps();
        gaps_on = 1'b0;
        program_timing(random_timing());
        for (int k = 0; k < 3; k++)
            run_command(2'($urandom_range(1, 3)), 8'($urandom), LVL_RANDOM, 1'b1);
        settle();
    endtask

    initial begin
        for (int i = 0; i < NUM_CFG; i++)
            timing[i] = CFG_DEFAULTS[i];
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_default_timing();
        test_short_slots();
        test_zero_slots();
        test_long_reset();
        test_random_traffic();
        test_no_gaps();
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== one_wire_bus_master_core.f =====
rtl/core/owbm_pkg.sv
rtl/core/owbm_front.sv
rtl/core/owbm_queue.sv
rtl/core/owbm_back.sv
rtl/core/one_wire_bus_master_core.sv
rtl/core/owbm_checker.sv
test/one_wire_bus_master_core_test.sv
